/* hdl/eor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package eor_pkg;

  localparam int POINT_BITS = 13;
  localparam int FRAME_BITS = 13;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ARC  = 2'd1;
  localparam logic [1:0] PH_TIP  = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic       load_start;
    logic       span;
    logic       mul_b;
    logic       mul_ab;
    logic       terms;
    logic       err_dx;
    logic       err_dy;
    logic       snap;
    logic       eval;
    logic       decide;
    logic [1:0] idx;
  } eor_cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       done;
  } eor_sts_t;

endpackage

`default_nettype wire

/* hdl/eor_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module eor_ctrl
  import eor_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     req_type,
  output logic     out_tvalid,
  input  logic     out_tready,
  output logic     out_tlast,
  output logic     figure_done,
  output eor_cmd_t cmd,
  input  eor_sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPAN   = 3'd1;
  localparam logic [2:0] ST_MUL_B  = 3'd2;
  localparam logic [2:0] ST_MUL_AB = 3'd3;
  localparam logic [2:0] ST_TERMS  = 3'd4;
  localparam logic [2:0] ST_ERR_DX = 3'd5;
  localparam logic [2:0] ST_ERR_DY = 3'd6;
  localparam logic [2:0] ST_STEP   = 3'd7;

  localparam logic [1:0] CALC_EVAL   = 2'd0;
  localparam logic [1:0] CALC_DECIDE = 2'd1;
  localparam logic [1:0] CALC_ADD_DY = 2'd2;
  localparam logic [1:0] CALC_DONE   = 2'd3;
  localparam logic [1:0] LAST_IDX    = 2'd3;

  logic [2:0] state_r, state_nxt;
  logic [1:0] calc_r, calc_nxt;
  logic [1:0] emit_r, emit_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       in_step;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = (state_r == ST_STEP) && ((emit_r != LAST_IDX) || (calc_r == CALC_DONE));
  assign out_acc    = out_tvalid & out_tready;
  assign out_tlast  = (emit_r == LAST_IDX);
  assign figure_done = out_tlast & sts.done;
  assign in_step    = (state_r == ST_STEP);

  always_comb begin
    cmd            = '0;
    cmd.load_start = in_acc && (req_type == REQ_START);
    cmd.snap       = in_acc && (req_type == REQ_STEP) && (sts.phase != PH_IDLE);
    cmd.span       = (state_r == ST_SPAN);
    cmd.mul_b      = (state_r == ST_MUL_B);
    cmd.mul_ab     = (state_r == ST_MUL_AB);
    cmd.terms      = (state_r == ST_TERMS);
    cmd.eval       = in_step && (calc_r == CALC_EVAL);
    cmd.decide     = in_step && (calc_r == CALC_DECIDE);
    cmd.err_dx     = (state_r == ST_ERR_DX) || (in_step && (calc_r == CALC_DECIDE));
    cmd.err_dy     = (state_r == ST_ERR_DY) || (in_step && (calc_r == CALC_ADD_DY));
    cmd.idx        = emit_r;
  end

  always_comb begin
    state_nxt = state_r;
    calc_nxt  = calc_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load_start) begin
          state_nxt = ST_SPAN;
        end else if (cmd.snap) begin
          state_nxt = ST_STEP;
          calc_nxt  = CALC_EVAL;
          emit_nxt  = 2'd0;
        end
      end
      ST_SPAN:   state_nxt = ST_MUL_B;
      ST_MUL_B:  state_nxt = ST_MUL_AB;
      ST_MUL_AB: state_nxt = ST_TERMS;
      ST_TERMS:  state_nxt = ST_ERR_DX;
      ST_ERR_DX: state_nxt = ST_ERR_DY;
      ST_ERR_DY: state_nxt = ST_IDLE;
      ST_STEP: begin
        if (calc_r != CALC_DONE) begin
          calc_nxt = calc_r + 2'd1;
        end
        if (out_acc) begin
          emit_nxt = emit_r + 2'd1;
          if (emit_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      calc_r  <= CALC_EVAL;
      emit_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      calc_r  <= calc_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/eor_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module eor_datapath
  import eor_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ERR_BITS   = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eor_cmd_t                     cmd,
  output eor_sts_t                     sts,
  input  logic signed [COORD_BITS-1:0] corner_a_x,
  input  logic signed [COORD_BITS-1:0] corner_a_y,
  input  logic signed [COORD_BITS-1:0] corner_b_x,
  input  logic signed [COORD_BITS-1:0] corner_b_y,
  input  logic [FRAME_BITS-1:0]        frame_width,
  input  logic [FRAME_BITS-1:0]        frame_height,
  output logic [POINT_BITS-1:0]        point_x,
  output logic [POINT_BITS-1:0]        point_y,
  output logic                         visible
);

  localparam int CB  = COORD_BITS;
  localparam int EB  = ERR_BITS;
  localparam int PW  = (CB + 2 > POINT_BITS + 1) ? CB + 2 : POINT_BITS + 1;
  localparam int SQW = 2 * CB;
  localparam int PRW = 3 * CB;

  logic [CB-1:0]        a_r, b_r;
  logic signed [CB-1:0] miny_r;
  logic signed [PW-1:0] left_r, right_r, upper_r, lower_r;
  logic [SQW-1:0]       aa_r, bb_r;
  logic [PRW-1:0]       prod_r;
  logic signed [EB-1:0] dx_r, dy_r, err_r;
  logic [EB-1:0]        incdx_r, incdy_r;
  logic                 cx_r, cy_r;
  logic [1:0]           phase_r;
  logic                 done_r;
  logic                 tip_s_r;
  logic signed [PW-1:0] sx0_r, sx1_r, sy0_r, sy1_r;

  logic signed [CB:0]   diff_x, diff_y;
  logic [CB-1:0]        a_in, b_in;
  logic signed [CB-1:0] minx_in, miny_in;
  logic [CB-1:0]        mul_a;
  logic [SQW-1:0]       mul_b;
  logic [PRW-1:0]       product;
  logic                 mul_en;
  logic signed [PW-1:0] half_sum;
  logic signed [EB:0]   e2, dx_ext, dy_ext;
  logic                 go_x, go_y;
  logic signed [PW-1:0] span_y;
  logic                 below, crossed;
  logic signed [PW-1:0] px, py;

  assign diff_x  = {corner_a_x[CB-1], corner_a_x} - {corner_b_x[CB-1], corner_b_x};
  assign diff_y  = {corner_a_y[CB-1], corner_a_y} - {corner_b_y[CB-1], corner_b_y};
  assign a_in    = diff_x[CB] ? CB'(-diff_x) : CB'(diff_x);
  assign b_in    = diff_y[CB] ? CB'(-diff_y) : CB'(diff_y);
  assign minx_in = diff_x[CB] ? corner_a_x : corner_b_x;
  assign miny_in = diff_y[CB] ? corner_a_y : corner_b_y;

  assign mul_a   = cmd.mul_b ? b_r : a_r;
  assign mul_b   = cmd.span ? SQW'(a_r) : (cmd.mul_b ? SQW'(b_r) : prod_r[SQW-1:0]);
  assign product = mul_a * mul_b;
  assign mul_en  = cmd.span | cmd.mul_b | cmd.mul_ab;

  assign half_sum = PW'(miny_r) + $signed(PW'(b_r >> 1));

  assign e2     = {err_r, 1'b0};
  assign dx_ext = {dx_r[EB-1], dx_r};
  assign dy_ext = {dy_r[EB-1], dy_r};
  assign go_x   = (e2 >= dx_ext);
  assign go_y   = (e2 <= dy_ext);

  assign span_y  = upper_r - lower_r;
  assign below   = (span_y < $signed(PW'(b_r)));
  assign crossed = (left_r > right_r);

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      a_r    <= a_in;
      b_r    <= b_in;
      miny_r <= miny_in;
      left_r <= PW'(minx_in);
    end
    if (cmd.span) begin
      right_r <= left_r + $signed(PW'(a_r));
      upper_r <= half_sum + $signed(PW'(b_r[0]));
      lower_r <= half_sum;
    end
    if (mul_en) begin
      prod_r <= product;
    end
    if (cmd.mul_b) begin
      aa_r <= prod_r[SQW-1:0];
    end
    if (cmd.mul_ab) begin
      bb_r <= prod_r[SQW-1:0];
    end
    if (cmd.terms) begin
      dx_r    <= (EB'(bb_r) - EB'(prod_r)) << 2;
      dy_r    <= b_r[0] ? EB'(aa_r) << 3 : EB'(aa_r) << 2;
      incdy_r <= EB'(aa_r) << 3;
      incdx_r <= EB'(bb_r) << 3;
      err_r   <= b_r[0] ? EB'(aa_r) : '0;
      cx_r    <= 1'b1;
      cy_r    <= 1'b1;
    end
    if (cmd.err_dx && cx_r) begin
      err_r <= err_r + dx_r;
    end
    if (cmd.err_dy && cy_r) begin
      err_r <= err_r + dy_r;
    end
    if (cmd.eval) begin
      if (phase_r == PH_ARC) begin
        cx_r <= go_x;
        cy_r <= go_y;
        if (go_x) begin
          left_r  <= left_r + PW'(1);
          right_r <= right_r - PW'(1);
          dx_r    <= dx_r + $signed(incdx_r);
        end
        if (go_y) begin
          upper_r <= upper_r + PW'(1);
          lower_r <= lower_r - PW'(1);
          dy_r    <= dy_r + $signed(incdy_r);
        end
      end else begin
        cx_r    <= 1'b0;
        cy_r    <= 1'b0;
        upper_r <= upper_r + PW'(1);
        lower_r <= lower_r - PW'(1);
      end
    end
    if (cmd.snap) begin
      tip_s_r <= (phase_r == PH_TIP);
      sx0_r   <= (phase_r == PH_TIP) ? left_r - PW'(1) : right_r;
      sx1_r   <= (phase_r == PH_TIP) ? right_r + PW'(1) : left_r;
      sy0_r   <= upper_r;
      sy1_r   <= lower_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else if (cmd.terms) begin
      phase_r <= PH_ARC;
      done_r  <= 1'b0;
    end else if (cmd.decide) begin
      done_r <= 1'b0;
      if (phase_r == PH_ARC) begin
        if (crossed) begin
          if (below) begin
            phase_r <= PH_TIP;
          end else begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end
        end
      end else if (!below) begin
        phase_r <= PH_IDLE;
        done_r  <= 1'b1;
      end
    end
  end

  assign sts.phase = phase_r;
  assign sts.done  = done_r;

  always_comb begin
    case (cmd.idx)
      2'd0:    px = sx0_r;
      2'd1:    px = sx1_r;
      2'd2:    px = tip_s_r ? sx0_r : sx1_r;
      default: px = tip_s_r ? sx1_r : sx0_r;
    endcase
    py = cmd.idx[1] ? sy1_r : sy0_r;
  end

  assign point_x = px[POINT_BITS-1:0];
  assign point_y = py[POINT_BITS-1:0];
  assign visible = !px[PW-1] && !py[PW-1] &&
                   ($unsigned(px) < PW'(frame_width)) &&
                   ($unsigned(py) < PW'(frame_height));

endmodule

`default_nettype wire

/* hdl/ellipse_outline_rasterizer_top.sv */
// Ellipse outline rasterizer: draws the outline of the ellipse inscribed in
// an axis-aligned rectangle, one Bresenham iteration per step request.
// Input stream: a beat with tuser = 0 loads two opposite corners from tdata
// and sets up the error terms; a beat with tuser = 1 asks for the next four
// mirrored outline points. A step beat with no figure running yields nothing.
// Output stream: four beats per step, each with x, y in tdata and visible and
// figure-done flags in tuser; tlast marks the fourth beat of every step.
// A start beat occupies the block through setup: one shared multiplier
// forms a*a, b*b and a*b*b in the span, mul_b and mul_ab states, then the
// terms state and two error-term adds. A step beat is accepted, then four
// output beats follow while the error update runs alongside; the fourth beat
// waits for the update to finish. One request is in flight at a time, so
// in_tready is low after acceptance until setup ends or the last output beat
// of that request is taken. A stalled receiver holds the current beat.
// Reset (rst_n low, synchronous) returns to idle with no figure running and
// frame size 1024 x 768. Frame size is written over the APB port at 0x0/0x4.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_outline_rasterizer_top
  import eor_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ERR_BITS   = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // req_type
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // point_x [12:0], point_y [25:13], zero fill
  output logic [31:0]                            out_tdata,
  // visible, figure_done
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [2:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int CB = COORD_BITS;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = FRAME_BITS'(1024);
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = FRAME_BITS'(768);

  logic [FRAME_BITS-1:0] frame_width_r, frame_height_r;
  logic                  cfg_wr;
  eor_cmd_t              cmd;
  eor_sts_t              sts;
  logic [POINT_BITS-1:0] point_x, point_y;
  logic                  visible, figure_done;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[FRAME_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FRAME_BITS-1:0];
        default:          frame_width_r  <= frame_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FRAME_WIDTH:  cfg_prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  eor_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .req_type    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .figure_done (figure_done),
    .cmd         (cmd),
    .sts         (sts)
  );

  eor_datapath #(
    .COORD_BITS (COORD_BITS),
    .ERR_BITS   (ERR_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .corner_a_x   ($signed(in_tdata[CB-1:0])),
    .corner_a_y   ($signed(in_tdata[2*CB-1:CB])),
    .corner_b_x   ($signed(in_tdata[3*CB-1:2*CB])),
    .corner_b_y   ($signed(in_tdata[4*CB-1:3*CB])),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .point_x      (point_x),
    .point_y      (point_y),
    .visible      (visible)
  );

  assign out_tdata = {(32 - 2*POINT_BITS)'(0), point_y, point_x};
  assign out_tuser = {figure_done, visible};

endmodule

`default_nettype wire

/* hdl/eor_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module eor_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // one request at a time: never taking input while a point is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while output beat pending");

  // a start beat yields no points and busies the block
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> (!in_tready && !out_tvalid))
    else $error("start beat not followed by setup");

  // figure done only on the last beat of a step
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("figure done outside last beat");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output beat changed");

endmodule

bind ellipse_outline_rasterizer_top eor_checker u_eor_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
